[rtl/nbf_pkg.sv]
package nbf_pkg;

    localparam int unsigned LEN_LIMIT = 128;
    localparam int unsigned LEN_W     = 8;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] PREFIX_FIRST  = 8'hFA;
    localparam logic [7:0] PREFIX_SECOND = 8'hDE;
    // alternating preamble, earliest bit first; every chunk starts on an even bit
    localparam logic [7:0] PRE_PATTERN   = 8'b1010_1010;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER  = 2'd1;

    localparam int unsigned PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE   = 4'd0;
    localparam pc_t PC_DATA   = 4'd8;
    localparam pc_t PC_FINISH = 4'd12;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_PRE,
        OP_TRL,
        OP_PAD,
        OP_N81_LO,
        OP_N81_HI,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        SEL_SYNC,
        SEL_PFX1,
        SEL_PFX2,
        SEL_DATA
    } sel_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_PRE,
        LD_TRL
    } load_t;

    typedef enum logic [2:0] {
        CN_NEXT,
        CN_ACCEPT,
        CN_LOOP,
        CN_LAST,
        CN_ALWAYS
    } cond_t;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        load_t load;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // bits are left aligned, earliest bit in bit 7
    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] len;
        logic       finish;
        logic       frame_last;
    } chunk_t;

endpackage

[rtl/nbf_ucode_rom.sv]
module nbf_ucode_rom (
    input  nbf_pkg::pc_t   pc,
    output nbf_pkg::uword_t word
);

    always_comb begin
        unique case (pc)
            4'd0: word = '{nbf_pkg::OP_IDLE,   nbf_pkg::SEL_DATA, nbf_pkg::LD_PRE,
                           nbf_pkg::CN_ACCEPT, nbf_pkg::PC_DATA};
            4'd1: word = '{nbf_pkg::OP_PRE,    nbf_pkg::SEL_SYNC, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_LOOP,   nbf_pkg::PC_IDLE};
            4'd2: word = '{nbf_pkg::OP_N81_LO, nbf_pkg::SEL_SYNC, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd3: word = '{nbf_pkg::OP_N81_HI, nbf_pkg::SEL_SYNC, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd4: word = '{nbf_pkg::OP_N81_LO, nbf_pkg::SEL_PFX1, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd5: word = '{nbf_pkg::OP_N81_HI, nbf_pkg::SEL_PFX1, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd6: word = '{nbf_pkg::OP_N81_LO, nbf_pkg::SEL_PFX2, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd7: word = '{nbf_pkg::OP_N81_HI, nbf_pkg::SEL_PFX2, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd8: word = '{nbf_pkg::OP_N81_LO, nbf_pkg::SEL_DATA, nbf_pkg::LD_NONE,
                           nbf_pkg::CN_NEXT,   nbf_pkg::PC_IDLE};
            4'd9: word = '{nbf_pkg::OP_N81_HI, nbf_pkg::SEL_DATA, nbf_pkg::LD_TRL,
                           nbf_pkg::CN_LAST,   nbf_pkg::PC_FINISH};
            4'd10: word = '{nbf_pkg::OP_TRL,   nbf_pkg::SEL_DATA, nbf_pkg::LD_NONE,
                            nbf_pkg::CN_LOOP,  nbf_pkg::PC_IDLE};
            4'd11: word = '{nbf_pkg::OP_PAD,   nbf_pkg::SEL_DATA, nbf_pkg::LD_NONE,
                            nbf_pkg::CN_NEXT,  nbf_pkg::PC_IDLE};
            4'd12: word = '{nbf_pkg::OP_FINISH, nbf_pkg::SEL_DATA, nbf_pkg::LD_NONE,
                            nbf_pkg::CN_ALWAYS, nbf_pkg::PC_IDLE};
            default: word = '{nbf_pkg::OP_IDLE, nbf_pkg::SEL_DATA, nbf_pkg::LD_NONE,
                               nbf_pkg::CN_ALWAYS, nbf_pkg::PC_IDLE};
        endcase
    end

endmodule

[rtl/nbf_sequencer.sv]
module nbf_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_packet_last,
    input  logic [7:0]          preamble_len,
    input  logic [7:0]          trailer_len,
    input  nbf_pkg::uword_t     word,
    input  logic                stall,
    input  logic [2:0]          cnt,
    output nbf_pkg::pc_t        pc,
    output nbf_pkg::chunk_t     chunk
);

    nbf_pkg::pc_t pc_reg, pc_next;
    logic [7:0]   rem_reg, rem_next;
    logic         inside_reg, inside_next;
    logic [7:0]   data_reg;
    logic         last_reg;

    logic         accept;
    logic         advance;
    logic         rem_big;
    logic [3:0]   loop_len;
    logic [7:0]   src_byte;
    logic [7:0]   pre_clamp;
    logic [7:0]   trl_clamp;

    assign pc       = pc_reg;
    assign s_ready  = (word.cond == nbf_pkg::CN_ACCEPT);
    assign accept   = s_valid && s_ready;
    assign advance  = !stall;
    assign rem_big  = (rem_reg > 8'd8);
    assign loop_len = rem_big ? 4'd8 : rem_reg[3:0];

    assign pre_clamp = (preamble_len > 8'(nbf_pkg::LEN_LIMIT)) ?
                       8'(nbf_pkg::LEN_LIMIT) : preamble_len;
    assign trl_clamp = (trailer_len > 8'(nbf_pkg::LEN_LIMIT)) ?
                       8'(nbf_pkg::LEN_LIMIT) : trailer_len;

    always_comb begin
        unique case (word.sel)
            nbf_pkg::SEL_SYNC: src_byte = nbf_pkg::SYNC_BYTE;
            nbf_pkg::SEL_PFX1: src_byte = nbf_pkg::PREFIX_FIRST;
            nbf_pkg::SEL_PFX2: src_byte = nbf_pkg::PREFIX_SECOND;
            nbf_pkg::SEL_DATA: src_byte = data_reg;
            default:           src_byte = data_reg;
        endcase
    end

    // chunk per op; N81 characters as two 5-bit halves
    always_comb begin
        chunk            = '0;
        chunk.frame_last = last_reg;
        unique case (word.op)
            nbf_pkg::OP_PRE: begin
                chunk.bits = nbf_pkg::PRE_PATTERN;
                chunk.len  = loop_len;
            end
            nbf_pkg::OP_TRL: begin
                chunk.len = loop_len;
            end
            nbf_pkg::OP_PAD: begin
                chunk.len = (cnt == 3'd0) ? 4'd0 : 4'd8 - {1'b0, cnt};
            end
            nbf_pkg::OP_N81_LO: begin
                chunk.bits = {1'b0, src_byte[0], src_byte[1], src_byte[2], src_byte[3],
                              3'b000};
                chunk.len  = 4'd5;
            end
            nbf_pkg::OP_N81_HI: begin
                chunk.bits = {src_byte[4], src_byte[5], src_byte[6], src_byte[7], 1'b1,
                              3'b000};
                chunk.len  = 4'd5;
            end
            nbf_pkg::OP_FINISH: begin
                chunk.finish = 1'b1;
            end
            default: begin
                chunk.len = 4'd0;
            end
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (advance) begin
            unique case (word.cond)
                nbf_pkg::CN_NEXT:   pc_next = pc_reg + 1'b1;
                nbf_pkg::CN_ACCEPT: begin
                    if (accept) begin
                        pc_next = inside_reg ? word.target : pc_reg + 1'b1;
                    end
                end
                nbf_pkg::CN_LOOP:   pc_next = rem_big ? pc_reg : pc_reg + 1'b1;
                nbf_pkg::CN_LAST:   pc_next = last_reg ? pc_reg + 1'b1 : word.target;
                nbf_pkg::CN_ALWAYS: pc_next = word.target;
                default:            pc_next = nbf_pkg::PC_IDLE;
            endcase
        end
    end

    always_comb begin
        rem_next = rem_reg;
        if (word.load == nbf_pkg::LD_PRE && accept) begin
            rem_next = pre_clamp;
        end else if (word.load == nbf_pkg::LD_TRL && advance) begin
            rem_next = trl_clamp;
        end else if ((word.op == nbf_pkg::OP_PRE || word.op == nbf_pkg::OP_TRL) && advance) begin
            rem_next = rem_big ? rem_reg - 8'd8 : 8'd0;
        end
    end

    always_comb begin
        inside_next = inside_reg;
        if (advance && word.op == nbf_pkg::OP_FINISH) begin
            inside_next = !last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= nbf_pkg::PC_IDLE;
            rem_reg    <= 8'd0;
            inside_reg <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            rem_reg    <= rem_next;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data_byte;
            last_reg <= s_packet_last;
        end
    end

endmodule

[rtl/nbf_packer.sv]
module nbf_packer (
    input  logic                aclk,
    input  logic                aresetn,
    input  nbf_pkg::chunk_t     chunk,
    output logic                stall,
    output logic [2:0]          cnt,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_frame_byte,
    output logic                m_frame_end,
    output logic                m_run_end
);

    logic [6:0]  acc_reg, acc_next;
    logic [2:0]  cnt_reg;
    logic [7:0]  stage_reg;
    logic        stage_valid_reg;
    logic        m_valid_reg;
    logic [7:0]  byte_reg;
    logic        frame_end_reg;
    logic        run_end_reg;

    logic [3:0]  total;
    logic        produces;
    logic [14:0] wide;
    logic [14:0] rem_mask;
    logic [7:0]  new_byte;
    logic        out_free;
    logic        advance;
    logic        push;

    assign total    = {1'b0, cnt_reg} + chunk.len;
    assign produces = total[3];
    assign wide     = ({8'd0, acc_reg} << chunk.len) |
                      ({7'd0, chunk.bits} >> (4'd8 - chunk.len));
    assign rem_mask = (15'd1 << total[2:0]) - 15'd1;
    assign new_byte = 8'(wide >> total[2:0]);
    assign acc_next = produces ? 7'(wide & rem_mask) : wide[6:0];

    // the staged byte goes out once we know whether another byte follows it
    assign out_free = !m_valid_reg || m_ready;
    assign stall    = (produces && stage_valid_reg && !out_free) ||
                      (chunk.finish && !out_free);
    assign cnt      = cnt_reg;
    assign advance  = !stall;
    assign push     = advance && ((produces && stage_valid_reg) || chunk.finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= 7'd0;
            cnt_reg         <= 3'd0;
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (advance) begin
                acc_reg <= acc_next;
                cnt_reg <= total[2:0];
                if (produces) begin
                    stage_valid_reg <= 1'b1;
                end else if (chunk.finish) begin
                    stage_valid_reg <= 1'b0;
                end
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produces) begin
            stage_reg <= new_byte;
        end
        if (push) begin
            byte_reg      <= stage_reg;
            frame_end_reg <= chunk.finish && chunk.frame_last;
            run_end_reg   <= chunk.finish;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = byte_reg;
    assign m_frame_end  = frame_end_reg;
    assign m_run_end    = run_end_reg;

endmodule

[rtl/n81_packet_bit_framer_core.sv]
// N81 packet bit framer.
// Input channel (s_*): one packet byte per beat, s_packet_last on the final byte.
// Output channel (m_*): packed frame bytes, earliest bit in bit 7. m_run_end marks
// the last output beat caused by an input beat, m_frame_end the zero-padded
// final byte of a frame (preamble, sync 0xFF, prefix 0xFA 0xDE, N81 payload,
// trailer zeros).
// Config channel (cfg_*): index 0 preamble length, index 1 trailer length; always
// ready; values above 128 act as 128. Write only while the block is idle.
// Timing: a small microcode program steps through the frame, one chunk of up to
// eight bits per cycle unless the packer stalls. A middle packet byte steps
// through accept, two N81 halves and finish. The first byte adds the preamble
// and the N81 sync and prefix characters, the last byte the trailer and a zero
// pad. A completed byte is held in a stage register until the next or finish.
// Reset (synchronous, aresetn low) restores lengths 32/16 and starts a new frame.
// When m_ready is low the sequencer holds as soon as a second byte needs the
// output register; no beat is dropped.
module n81_packet_bit_framer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_packet_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_frame_byte,
    output logic                           m_frame_end,
    output logic                           m_run_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);

    logic [7:0] preamble_len_reg;
    logic [7:0] trailer_len_reg;

    nbf_pkg::pc_t        pc;
    nbf_pkg::uword_t     word;
    nbf_pkg::chunk_t     chunk;
    logic                pack_stall;
    logic [2:0]          pack_cnt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_len_reg <= 8'd32;
            trailer_len_reg  <= 8'd16;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                nbf_pkg::CFG_PREAMBLE: preamble_len_reg <= cfg_data;
                nbf_pkg::CFG_TRAILER:  trailer_len_reg  <= cfg_data;
                default: begin
                    preamble_len_reg <= preamble_len_reg;
                end
            endcase
        end
    end

    nbf_ucode_rom u_rom (
        .pc   (pc),
        .word (word)
    );

    nbf_sequencer u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_packet_last (s_packet_last),
        .preamble_len  (preamble_len_reg),
        .trailer_len   (trailer_len_reg),
        .word          (word),
        .stall         (pack_stall),
        .cnt           (pack_cnt),
        .pc            (pc),
        .chunk         (chunk)
    );

    nbf_packer u_pack (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .chunk        (chunk),
        .stall        (pack_stall),
        .cnt          (pack_cnt),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end),
        .m_run_end    (m_run_end)
    );

endmodule

[rtl/nbf_checker.sv]
module nbf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_byte,
    input logic       m_frame_end,
    input logic       m_run_end
);

    // frame close always ends the run of the byte that caused it
    a_frame_end_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_end)
        else $error("frame_end without run_end");

    // a new input beat never follows directly on an accepted one
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // result channel is empty right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) &&
        $stable(m_frame_end) && $stable(m_run_end))
        else $error("stalled output beat changed");

endmodule

bind n81_packet_bit_framer_core nbf_checker u_nbf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_frame_end  (m_frame_end),
    .m_run_end    (m_run_end)
);
